[sv/lts_pkg.sv]
// Link traffic statistics: shared types, opcodes, row layout and helpers.
// No dependencies; imported by every other file of the block.
`default_nettype none

package lts_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned DepthW = 16;
  localparam int unsigned SelW   = 4;
  localparam int unsigned StatW  = 64;

  // Event opcodes
  localparam logic [OpW-1:0] OpRxPkt  = 3'd0;
  localparam logic [OpW-1:0] OpTxPkt  = 3'd1;
  localparam logic [OpW-1:0] OpRxDrop = 3'd2;
  localparam logic [OpW-1:0] OpTxDrop = 3'd3;
  localparam logic [OpW-1:0] OpDepth  = 3'd4;
  localparam logic [OpW-1:0] OpRead   = 3'd5;

  // Statistics RAM: one row per direction plus a row for drops and depths
  localparam int unsigned NumRows = 3;
  localparam int unsigned RowAw   = $clog2(NumRows);
  localparam int unsigned NumWords = 5;
  localparam int unsigned WordAw   = $clog2(NumWords);

  localparam logic [RowAw-1:0] RowRx   = 2'd0;
  localparam logic [RowAw-1:0] RowTx   = 2'd1;
  localparam logic [RowAw-1:0] RowMisc = 2'd2;

  // Words of a direction row
  localparam logic [WordAw-1:0] WCount = 3'd0;
  localparam logic [WordAw-1:0] WBytes = 3'd1;
  localparam logic [WordAw-1:0] WLast  = 3'd2;
  localparam logic [WordAw-1:0] WAvg   = 3'd3;
  localparam logic [WordAw-1:0] WPeak  = 3'd4;
  // Words of the misc row
  localparam logic [WordAw-1:0] WRxDrop  = 3'd0;
  localparam logic [WordAw-1:0] WTxDrop  = 3'd1;
  localparam logic [WordAw-1:0] WRxDepth = 3'd2;
  localparam logic [WordAw-1:0] WTxDepth = 3'd3;

  // Selector codes that start the tx and misc groups, and the last valid code
  localparam logic [SelW-1:0] SelTxBase   = 4'd5;
  localparam logic [SelW-1:0] SelMiscBase = 4'd10;
  localparam logic [SelW-1:0] SelLast     = 4'd13;

  typedef logic [NumWords-1:0][StatW-1:0] row_t;

  // Request as it sits in the update stage
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic              wr;      // enabled update event
    logic              rd;      // counter read
    logic [RowAw-1:0]  row;
    logic [WordAw-1:0] word;
    logic              sel_ok;  // selector names a statistic
    logic [SelW-1:0]   sel;
    logic [ByteW-1:0]  bytes;
    logic [TimeW-1:0]  now;
    logic [DepthW-1:0] rxd;
    logic [DepthW-1:0] txd;
  } req_t;

  function automatic logic [RowAw-1:0] sel_row(logic [SelW-1:0] sel);
    if (sel < SelTxBase) return RowRx;
    if (sel < SelMiscBase) return RowTx;
    return RowMisc;
  endfunction

  function automatic logic [WordAw-1:0] sel_word(logic [SelW-1:0] sel);
    logic [SelW-1:0] w;
    if (sel < SelTxBase) w = sel;
    else if (sel < SelMiscBase) w = sel - SelTxBase;
    else w = sel - SelMiscBase;
    return w[WordAw-1:0];
  endfunction

  function automatic logic [StatW-1:0] sat_add(logic [StatW-1:0] a, logic [StatW-1:0] b);
    logic [StatW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[StatW] ? {StatW{1'b1}} : s[StatW-1:0];
  endfunction

  // floor((7*a + g) / 8), exact at 67 bits
  function automatic logic [StatW-1:0] blend(logic [StatW-1:0] a, logic [StatW-1:0] g);
    logic [StatW+2:0] x;
    logic [StatW+2:0] s;
    x = {3'b000, a};
    s = (x << 3) - x + {3'b000, g};
    return s[StatW+2:3];
  endfunction

endpackage

`default_nettype wire

[sv/lts_in_if.sv]
// Link traffic statistics: event request channel (valid/ready + event fields).
// Depends on lts_pkg.
`default_nettype none

interface lts_in_if;
  import lts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ByteW-1:0]  byte_count;
  logic [TimeW-1:0]  timestamp_ns;
  logic [DepthW-1:0] rx_depth;
  logic [DepthW-1:0] tx_depth;
  logic [SelW-1:0]   counter_select;

  modport source (
    output valid, opcode, byte_count, timestamp_ns, rx_depth, tx_depth, counter_select,
    input  ready
  );
  modport sink (
    input  valid, opcode, byte_count, timestamp_ns, rx_depth, tx_depth, counter_select,
    output ready
  );
endinterface

`default_nettype wire

[sv/lts_out_if.sv]
// Link traffic statistics: read result channel (valid/ready + read value).
// Depends on lts_pkg.
`default_nettype none

interface lts_out_if;
  import lts_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] read_value;
  logic [SelW-1:0]  read_index;

  modport source (output valid, read_value, read_index, input ready);
  modport sink   (input valid, read_value, read_index, output ready);
endinterface

`default_nettype wire

[sv/lts_stat_ram.sv]
// Link traffic statistics: row RAM, registered read, per-row valid.
// Rows never written read as zero. Depends on lts_pkg.
`default_nettype none

module lts_stat_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [lts_pkg::RowAw-1:0] rd_addr_i,
  output lts_pkg::row_t             rd_data_o,
  input  logic                      wr_en_i,
  input  logic [lts_pkg::RowAw-1:0] wr_addr_i,
  input  lts_pkg::row_t             wr_data_i
);
  import lts_pkg::*;

  row_t               mem [NumRows];
  logic [NumRows-1:0] row_vld_q;
  row_t               rd_data_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[sv/lts_update.sv]
// Link traffic statistics: row update (saturating counts, gap average/peak,
// depth watermarks) and read word selection. Depends on lts_pkg.
`default_nettype none

module lts_update (
  input  lts_pkg::req_t             req_i,
  input  lts_pkg::row_t             cur_i,
  output lts_pkg::row_t             new_o,
  output logic [lts_pkg::StatW-1:0] rd_value_o
);
  import lts_pkg::*;

  logic [StatW-1:0] last;
  logic [StatW-1:0] avg;
  logic [StatW-1:0] gap;
  logic             take_gap;

  assign last     = cur_i[WLast];
  assign avg      = cur_i[WAvg];
  assign gap      = req_i.now - last;
  assign take_gap = (last != '0) && (req_i.now >= last);

  always_comb begin
    new_o = cur_i;
    case (req_i.op)
      OpRxPkt, OpTxPkt: begin
        new_o[WCount] = sat_add(cur_i[WCount], StatW'(1));
        new_o[WBytes] = sat_add(cur_i[WBytes], StatW'(req_i.bytes));
        new_o[WLast]  = req_i.now;
        if (take_gap) begin
          new_o[WAvg] = (avg == '0) ? gap : blend(avg, gap);
          if (gap > cur_i[WPeak]) begin
            new_o[WPeak] = gap;
          end
        end
      end
      OpRxDrop: new_o[WRxDrop] = sat_add(cur_i[WRxDrop], StatW'(1));
      OpTxDrop: new_o[WTxDrop] = sat_add(cur_i[WTxDrop], StatW'(1));
      OpDepth: begin
        if (req_i.rxd > cur_i[WRxDepth][DepthW-1:0]) begin
          new_o[WRxDepth] = StatW'(req_i.rxd);
        end
        if (req_i.txd > cur_i[WTxDepth][DepthW-1:0]) begin
          new_o[WTxDepth] = StatW'(req_i.txd);
        end
      end
      default: new_o = cur_i;
    endcase
  end

  assign rd_value_o = req_i.sel_ok ? cur_i[req_i.word] : '0;

endmodule

`default_nettype wire

[sv/link_traffic_statistics.sv]
// Link traffic statistics top level: event pipeline around the statistics RAM.
// Depends on lts_pkg, lts_in_if, lts_out_if, lts_stat_ram, lts_update.
`default_nettype none

// Link traffic statistics. Events arrive on req_i: rx/tx packet (byte count,
// timestamp), rx/tx drop, queue-depth sample, or counter read. All state sits
// in a three-row RAM (rx row, tx row, drop/depth row) that reads back zero
// until first written. An event reads its row at accept, the next cycle
// updates it (64-bit saturating counts, gap average (7*avg+gap)/8 and peak,
// depth watermarks) and writes it back; a write-register bypass covers an
// event that follows one to the same row. One event is taken every cycle
// unless req_i is stalled; a read result goes from the update stage into
// an output register and is held valid on rsp_o until taken. A read is
// held in the update stage only while the output register is full and not
// being taken, which then stalls req_i. Update events are ignored while cfg
// enable is 0; reads always answer.
module link_traffic_statistics (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  lts_in_if.sink    req_i,
  lts_out_if.source rsp_o
);
  import lts_pkg::*;

  logic             enable_q;
  req_t             req_d, s1_q;
  logic             s1_vld_q;
  logic             s1_go;
  logic             accept;
  row_t             ram_rd;
  row_t             cur_row;
  row_t             new_row;
  logic [StatW-1:0] rd_value;
  logic             wr_en;
  // bypass of the last row write
  logic             wb_vld_q;
  logic [RowAw-1:0] wb_row_q;
  row_t             wb_data_q;
  // output register
  logic             out_vld_q;
  logic [StatW-1:0] out_value_q;
  logic [SelW-1:0]  out_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Update stage moves on unless it holds a read facing a full output register that is not being taken
  assign s1_go       = !(s1_vld_q && s1_q.rd) || !out_vld_q || rsp_o.ready;
  assign req_i.ready = !s1_vld_q || s1_go;
  assign accept      = req_i.valid && req_i.ready;

  // Decode the incoming request
  always_comb begin
    req_d.op     = req_i.opcode;
    req_d.wr     = enable_q && (req_i.opcode <= OpDepth);
    req_d.rd     = (req_i.opcode == OpRead);
    req_d.sel    = req_i.counter_select;
    req_d.sel_ok = (req_i.counter_select <= SelLast);
    req_d.word   = sel_word(req_i.counter_select);
    req_d.bytes  = req_i.byte_count;
    req_d.now    = req_i.timestamp_ns;
    req_d.rxd    = req_i.rx_depth;
    req_d.txd    = req_i.tx_depth;
    case (req_i.opcode)
      OpRxPkt: req_d.row = RowRx;
      OpTxPkt: req_d.row = RowTx;
      OpRead:  req_d.row = sel_row(req_i.counter_select);
      default: req_d.row = RowMisc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= req_d;
    end
  end

  lts_stat_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (req_d.row),
    .rd_data_o (ram_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_q.row),
    .wr_data_i (new_row)
  );

  // RAM read data can miss the write made in the cycle of its read
  assign cur_row = (wb_vld_q && (wb_row_q == s1_q.row)) ? wb_data_q : ram_rd;

  lts_update u_update (
    .req_i      (s1_q),
    .cur_i      (cur_row),
    .new_o      (new_row),
    .rd_value_o (rd_value)
  );

  assign wr_en = s1_vld_q && s1_q.wr && s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (wr_en) begin
      wb_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wb_row_q  <= s1_q.row;
      wb_data_q <= new_row;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_vld_q && s1_q.rd && s1_go) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && s1_q.rd && s1_go) begin
      out_value_q <= rd_value;
      out_index_q <= s1_q.sel;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.read_index = out_index_q;

  // A read never writes the RAM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !s1_q.rd)
    else $error("RAM write from a read request");

  // A read leaving the update stage lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_q.rd && s1_go) |=> out_vld_q)
    else $error("read result lost");

  // A held update stage blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_go) |-> !req_i.ready)
    else $error("request taken while update stage held");

endmodule

`default_nettype wire
